// ----- src/bankers_safety_check_unit_macros.svh -----
// ----------------------------------------------------------------------------
// bankers_safety_check_unit_macros
// Assertion macros used by the checker file of the safety check unit.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_CHECK_UNIT_MACROS_SVH
`define BANKERS_SAFETY_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// Next-cycle implication, disabled during reset.
`define BSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

// ----- src/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and codes shared by the banker's safety check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_AVAIL   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_LOADED  = 3'd0;
    localparam logic [2:0] STAT_INVALID = 3'd1;
    localparam logic [2:0] STAT_BLOCKED = 3'd2;
    localparam logic [2:0] STAT_SAFE    = 3'd3;
    localparam logic [2:0] STAT_UNSAFE  = 3'd4;

    // One process row as stored in the row memory
    typedef struct packed {
        logic [7:0] alloc_a;
        logic [7:0] alloc_b;
        logic [7:0] alloc_c;
        logic [7:0] need_a;
        logic [7:0] need_b;
        logic [7:0] need_c;
    } bsc_row_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_CHK,
        ST_SCAN,
        ST_FINAL,
        ST_SO_RD,
        ST_SO_OUT
    } bsc_state_t;

endpackage

`default_nettype wire

// ----- src/bsc_ram.sv -----
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/bankers_safety_check_unit.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check_unit
// Banker's algorithm deadlock avoidance over three resource types.
// ----------------------------------------------------------------------------
// Row loads and available-count writes each give one result.
// A request reads its row, then checks it, and then the
// safety scan streams PROCESSES*PROCESSES row reads out of the row memory,
// one row test per cycle. A granted request then gives one result per entry
// of the safe order, each read from the order memory and then presented.
// The scan's work vector update sets the row test rate.
`default_nettype none

module bankers_safety_check_unit import bsc_pkg::*; #(
    parameter int PROCESSES = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [2:0] process,
    input  wire logic [7:0] amount_a,
    input  wire logic [7:0] amount_b,
    input  wire logic [7:0] amount_c,
    input  wire logic [7:0] need_a,
    input  wire logic [7:0] need_b,
    input  wire logic [7:0] need_c,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      status,
    output logic [2:0]      order_process,
    output logic            last
);

    localparam int IDX_W = $clog2(PROCESSES);
    localparam int CNT_W = $clog2(PROCESSES + 1);
    localparam logic [4:0] PROC_LIM = 5'(PROCESSES);
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(PROCESSES - 1);
    localparam logic [CNT_W-1:0] K_LAST = CNT_W'(PROCESSES - 1);

    bsc_state_t state_reg, state_next;

    logic [7:0]  avail_a_reg, avail_b_reg, avail_c_reg;
    logic [7:0]  avail_a_next, avail_b_next, avail_c_next;
    logic [11:0] work_a_reg, work_b_reg, work_c_reg;
    logic [11:0] work_a_next, work_b_next, work_c_next;
    logic [7:0]  amt_a_reg, amt_b_reg, amt_c_reg;
    logic [7:0]  amt_a_next, amt_b_next, amt_c_next;
    logic [2:0]  proc_reg, proc_next;
    bsc_row_t    orig_row_reg, orig_row_next;
    logic [PROCESSES-1:0] row_vld_reg, row_vld_next;
    logic [PROCESSES-1:0] fin_reg, fin_next;
    logic [IDX_W-1:0] rd_row_reg, rd_row_next;
    logic [IDX_W-1:0] rd_pass_reg, rd_pass_next;
    logic        rd_act_reg, rd_act_next;
    logic        ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0] ev_row_reg, ev_row_next;
    logic        ev_done_reg, ev_done_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic        rvld_q_reg, rvld_q_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [2:0]  order_reg, order_next;
    logic        last_reg, last_next;

    // Row memory ports
    logic             row_we, row_re;
    logic [IDX_W-1:0] row_waddr, row_raddr;
    bsc_row_t         row_wdata, row_rdata, row_q;

    // Safe order memory ports
    logic             so_we, so_re;
    logic [IDX_W-1:0] so_waddr, so_raddr;
    logic [2:0]       so_wdata, so_rdata;

    logic             ofree;
    logic [4:0]       in_proc_ext, reg_proc_ext, ev_row_ext;
    logic             in_range;
    logic [IDX_W-1:0] in_idx, reg_idx;
    logic             over_need, over_alloc, over_avail, fits;
    logic [8:0]       sum_a, sum_b, sum_c;

    bsc_ram #(.WIDTH($bits(bsc_row_t)), .DEPTH(PROCESSES)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    bsc_ram #(.WIDTH(3), .DEPTH(PROCESSES)) u_order_ram (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .re    (so_re),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

    // Rows never written read as zero
    assign row_q = rvld_q_reg ? row_rdata : '0;

    assign ofree        = !out_valid_reg || out_ready;
    assign in_proc_ext  = {2'b00, process};
    assign reg_proc_ext = {2'b00, proc_reg};
    assign ev_row_ext   = 5'(ev_row_reg);
    assign in_range     = in_proc_ext < PROC_LIM;
    assign in_idx       = IDX_W'(in_proc_ext);
    assign reg_idx      = IDX_W'(reg_proc_ext);

    // Request checks against the fetched row
    assign sum_a = {1'b0, row_q.alloc_a} + {1'b0, amt_a_reg};
    assign sum_b = {1'b0, row_q.alloc_b} + {1'b0, amt_b_reg};
    assign sum_c = {1'b0, row_q.alloc_c} + {1'b0, amt_c_reg};
    assign over_need  = (amt_a_reg > row_q.need_a) || (amt_b_reg > row_q.need_b)
                     || (amt_c_reg > row_q.need_c);
    assign over_alloc = sum_a[8] || sum_b[8] || sum_c[8];
    assign over_avail = (amt_a_reg > avail_a_reg) || (amt_b_reg > avail_b_reg)
                     || (amt_c_reg > avail_c_reg);

    // Row test of the scan
    assign fits = !fin_reg[ev_row_reg]
               && ({4'b0, row_q.need_a} <= work_a_reg)
               && ({4'b0, row_q.need_b} <= work_b_reg)
               && ({4'b0, row_q.need_c} <= work_c_reg);

    assign in_ready      = (state_reg == ST_IDLE) && ofree;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign order_process = order_reg;
    assign last          = last_reg;

    // Sequencer: next state, memory access and result loading
    always_comb
    begin
        state_next     = state_reg;
        avail_a_next   = avail_a_reg;
        avail_b_next   = avail_b_reg;
        avail_c_next   = avail_c_reg;
        work_a_next    = work_a_reg;
        work_b_next    = work_b_reg;
        work_c_next    = work_c_reg;
        amt_a_next     = amt_a_reg;
        amt_b_next     = amt_b_reg;
        amt_c_next     = amt_c_reg;
        proc_next      = proc_reg;
        orig_row_next  = orig_row_reg;
        row_vld_next   = row_vld_reg;
        fin_next       = fin_reg;
        rd_row_next    = rd_row_reg;
        rd_pass_next   = rd_pass_reg;
        rd_act_next    = rd_act_reg;
        ev_vld_next    = 1'b0;
        ev_row_next    = ev_row_reg;
        ev_done_next   = 1'b0;
        len_next       = len_reg;
        k_next         = k_reg;
        rvld_q_next    = rvld_q_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        order_next     = order_reg;
        last_next      = last_reg;
        row_we         = 1'b0;
        row_waddr      = reg_idx;
        row_wdata      = orig_row_reg;
        row_re         = 1'b0;
        row_raddr      = reg_idx;
        so_we          = 1'b0;
        so_waddr       = IDX_W'(len_reg);
        so_wdata       = ev_row_ext[2:0];
        so_re          = 1'b0;
        so_raddr       = IDX_W'(k_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    proc_next  = process;
                    amt_a_next = amount_a;
                    amt_b_next = amount_b;
                    amt_c_next = amount_c;
                    case (kind)
                        KIND_LOAD:
                        begin
                            if (in_range)
                            begin
                                row_we    = 1'b1;
                                row_waddr = in_idx;
                                row_wdata = '{alloc_a: amount_a, alloc_b: amount_b,
                                              alloc_c: amount_c, need_a: need_a,
                                              need_b: need_b, need_c: need_c};
                                row_vld_next[in_idx] = 1'b1;
                            end
                            out_valid_next = 1'b1;
                            status_next    = STAT_LOADED;
                            order_next     = 3'd0;
                            last_next      = 1'b1;
                        end
                        KIND_AVAIL:
                        begin
                            avail_a_next   = amount_a;
                            avail_b_next   = amount_b;
                            avail_c_next   = amount_c;
                            out_valid_next = 1'b1;
                            status_next    = STAT_LOADED;
                            order_next     = 3'd0;
                            last_next      = 1'b1;
                        end
                        KIND_REQUEST:
                        begin
                            if (in_range)
                            begin
                                row_re      = 1'b1;
                                row_raddr   = in_idx;
                                rvld_q_next = row_vld_reg[in_idx];
                                state_next  = ST_REQ_CHK;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STAT_INVALID;
                                order_next     = 3'd0;
                                last_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused kind: drop the item
                        end
                    endcase
                end
            end

            ST_REQ_CHK:
            begin
                if (ofree)
                begin
                    if (over_need || over_alloc || over_avail)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = (over_need || over_alloc) ? STAT_INVALID
                                                                   : STAT_BLOCKED;
                        order_next     = 3'd0;
                        last_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // Grant tentatively and start the scan
                        orig_row_next = row_q;
                        row_we        = 1'b1;
                        row_wdata     = '{alloc_a: sum_a[7:0], alloc_b: sum_b[7:0],
                                          alloc_c: sum_c[7:0],
                                          need_a: row_q.need_a - amt_a_reg,
                                          need_b: row_q.need_b - amt_b_reg,
                                          need_c: row_q.need_c - amt_c_reg};
                        row_vld_next[reg_idx] = 1'b1;
                        avail_a_next  = avail_a_reg - amt_a_reg;
                        avail_b_next  = avail_b_reg - amt_b_reg;
                        avail_c_next  = avail_c_reg - amt_c_reg;
                        work_a_next   = {4'b0, avail_a_reg - amt_a_reg};
                        work_b_next   = {4'b0, avail_b_reg - amt_b_reg};
                        work_c_next   = {4'b0, avail_c_reg - amt_c_reg};
                        fin_next      = '0;
                        len_next      = '0;
                        rd_row_next   = '0;
                        rd_pass_next  = '0;
                        rd_act_next   = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next row read
                if (rd_act_reg)
                begin
                    row_re       = 1'b1;
                    row_raddr    = rd_row_reg;
                    rvld_q_next  = row_vld_reg[rd_row_reg];
                    ev_vld_next  = 1'b1;
                    ev_row_next  = rd_row_reg;
                    ev_done_next = (rd_row_reg == ROW_LAST) && (rd_pass_reg == ROW_LAST);
                    if (rd_row_reg == ROW_LAST)
                    begin
                        rd_row_next  = '0;
                        rd_pass_next = rd_pass_reg + 1'b1;
                        if (rd_pass_reg == ROW_LAST)
                        begin
                            rd_act_next = 1'b0;
                        end
                    end
                    else
                    begin
                        rd_row_next = rd_row_reg + 1'b1;
                    end
                end
                // Test the row that came back
                if (ev_vld_reg)
                begin
                    if (fits)
                    begin
                        fin_next[ev_row_reg] = 1'b1;
                        work_a_next = work_a_reg + {4'b0, row_q.alloc_a};
                        work_b_next = work_b_reg + {4'b0, row_q.alloc_b};
                        work_c_next = work_c_reg + {4'b0, row_q.alloc_c};
                        so_we       = 1'b1;
                        len_next    = len_reg + 1'b1;
                    end
                    if (ev_done_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (&fin_reg)
                begin
                    k_next     = '0;
                    state_next = ST_SO_RD;
                end
                else if (ofree)
                begin
                    // Roll back the grant
                    row_we         = 1'b1;
                    row_wdata      = orig_row_reg;
                    avail_a_next   = avail_a_reg + amt_a_reg;
                    avail_b_next   = avail_b_reg + amt_b_reg;
                    avail_c_next   = avail_c_reg + amt_c_reg;
                    out_valid_next = 1'b1;
                    status_next    = STAT_UNSAFE;
                    order_next     = 3'd0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SO_RD:
            begin
                so_re      = 1'b1;
                state_next = ST_SO_OUT;
            end

            ST_SO_OUT:
            begin
                if (ofree)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_SAFE;
                    order_next     = so_rdata;
                    last_next      = (k_reg == K_LAST);
                    if (k_reg == K_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SO_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avail_a_reg   <= '0;
            avail_b_reg   <= '0;
            avail_c_reg   <= '0;
            work_a_reg    <= '0;
            work_b_reg    <= '0;
            work_c_reg    <= '0;
            row_vld_reg   <= '0;
            fin_reg       <= '0;
            rd_act_reg    <= 1'b0;
            ev_vld_reg    <= 1'b0;
            ev_done_reg   <= 1'b0;
            len_reg       <= '0;
            k_reg         <= '0;
            rvld_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            avail_a_reg   <= avail_a_next;
            avail_b_reg   <= avail_b_next;
            avail_c_reg   <= avail_c_next;
            work_a_reg    <= work_a_next;
            work_b_reg    <= work_b_next;
            work_c_reg    <= work_c_next;
            row_vld_reg   <= row_vld_next;
            fin_reg       <= fin_next;
            rd_act_reg    <= rd_act_next;
            ev_vld_reg    <= ev_vld_next;
            ev_done_reg   <= ev_done_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            rvld_q_reg    <= rvld_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        amt_a_reg    <= amt_a_next;
        amt_b_reg    <= amt_b_next;
        amt_c_reg    <= amt_c_next;
        proc_reg     <= proc_next;
        orig_row_reg <= orig_row_next;
        rd_row_reg   <= rd_row_next;
        rd_pass_reg  <= rd_pass_next;
        ev_row_reg   <= ev_row_next;
        status_reg   <= status_next;
        order_reg    <= order_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

// ----- src/bsc_checker.sv -----
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks of the result stream of the safety check unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bankers_safety_check_unit_macros.svh"

module bsc_checker import bsc_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [2:0] order_process,
    input wire logic       last
);

    // Every status other than a safe order is a single, last item
    `BSC_ASSERT_NOW(a_single_last, out_valid && (status != STAT_SAFE), last)

    // Order index is zero outside a safe order
    `BSC_ASSERT_NOW(a_order_zero, out_valid && (status != STAT_SAFE), order_process == 3'd0)

    // No input accepted while a safe order is mid-stream
    `BSC_ASSERT_NOW(a_no_accept_mid, out_valid && (status == STAT_SAFE) && !last, !in_ready)

    // A stalled result holds
    `BSC_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(order_process) && $stable(last))

endmodule

bind bankers_safety_check_unit bsc_checker u_bsc_checker (.*);

`default_nettype wire

// ----- test/bankers_safety_check_unit_test.sv -----
// ----------------------------------------------------------------------------
// bankers_safety_check_unit_test
// Drives row loads, available-count writes and requests into the safety
// check unit, predicts each result with its own banker's state, and checks
// status, safe order and last mark under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bankers_safety_check_unit_test;
    import bsc_pkg::*;

    localparam int NPROC = 8;

    typedef struct {
        logic [2:0] status;
        logic [2:0] order_process;
        logic       last;
    } grant_result_t;

    // Banker's state copy and queue of expected results
    class grant_scoreboard;
        logic [7:0]    avail_q [3];
        logic [7:0]    alloc_q [NPROC][3];
        logic [7:0]    need_q  [NPROC][3];
        grant_result_t pending [$];
        int            errors;

        function new();
            errors = 0;
            foreach (avail_q[r]) avail_q[r] = 0;
            for (int p = 0; p < NPROC; p++)
                for (int r = 0; r < 3; r++)
                begin
                    alloc_q[p][r] = 0;
                    need_q[p][r] = 0;
                end
        endfunction

        function void push_one(logic [2:0] st);
            grant_result_t res;
            res.status = st;
            res.order_process = 0;
            res.last = 1;
            pending.insert(pending.size(), res);
        endfunction

        // Run the safety scan; fill the order and return whether all finish
        function bit scan_safe(output int seq [$]);
            bit   done [NPROC];
            int   work [3];
            bit   fits;
            seq = {};
            foreach (done[p]) done[p] = 0;
            for (int r = 0; r < 3; r++) work[r] = avail_q[r];
            for (int pass = 0; pass < NPROC; pass++)
                for (int p = 0; p < NPROC; p++)
                begin
                    fits = 1;
                    for (int r = 0; r < 3; r++)
                        if (need_q[p][r] > work[r]) fits = 0;
                    if (!done[p] && fits)
                    begin
                        done[p] = 1;
                        for (int r = 0; r < 3; r++)
                            work[r] = (work[r] + alloc_q[p][r]) & 12'hFFF;
                        seq.insert(seq.size(), p);
                    end
                end
            return seq.size() == NPROC;
        endfunction

        // Note an accepted item and queue what it causes
        function void note_item(logic [1:0] k, logic [2:0] p,
                                logic [7:0] amt [3], logic [7:0] nd [3]);
            int  seq [$];
            bit  bad;
            grant_result_t res;
            if (k == KIND_LOAD)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    alloc_q[p][r] = amt[r];
                    need_q[p][r] = nd[r];
                end
                push_one(STAT_LOADED);
            end
            else if (k == KIND_AVAIL)
            begin
                for (int r = 0; r < 3; r++) avail_q[r] = amt[r];
                push_one(STAT_LOADED);
            end
            else if (k == KIND_REQUEST)
            begin
                bad = 0;
                for (int r = 0; r < 3; r++)
                    if (amt[r] > need_q[p][r] || int'(alloc_q[p][r]) + amt[r] > 255)
                        bad = 1;
                if (bad)
                    push_one(STAT_INVALID);
                else
                begin
                    for (int r = 0; r < 3; r++)
                        if (amt[r] > avail_q[r]) bad = 1;
                    if (bad)
                        push_one(STAT_BLOCKED);
                    else
                    begin
                        for (int r = 0; r < 3; r++)
                        begin
                            avail_q[r] -= amt[r];
                            alloc_q[p][r] += amt[r];
                            need_q[p][r] -= amt[r];
                        end
                        if (scan_safe(seq))
                            foreach (seq[i])
                            begin
                                res.status = STAT_SAFE;
                                res.order_process = 3'(seq[i]);
                                res.last = (i == seq.size() - 1);
                                pending.insert(pending.size(), res);
                            end
                        else
                        begin
                            // roll back the tentative grant
                            for (int r = 0; r < 3; r++)
                            begin
                                avail_q[r] += amt[r];
                                alloc_q[p][r] -= amt[r];
                                need_q[p][r] += amt[r];
                            end
                            push_one(STAT_UNSAFE);
                        end
                    end
                end
            end
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic [2:0] st, logic [2:0] op, logic lst);
            grant_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status %0d order %0d last %0d", st, op, lst);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (st !== exp_r.status)
            begin
                $error("status: expected %0d actual %0d", exp_r.status, st);
                errors++;
            end
            if (op !== exp_r.order_process)
            begin
                $error("order_process: expected %0d actual %0d", exp_r.order_process, op);
                errors++;
            end
            if (lst !== exp_r.last)
            begin
                $error("last: expected %0d actual %0d", exp_r.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [2:0] process;
    logic [7:0] amount_a, amount_b, amount_c;
    logic [7:0] need_a, need_b, need_c;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] status;
    logic [2:0] order_process;
    logic       last;

    grant_scoreboard board;
    bit  calm;          // no idling in the last part
    int  hold_cycles;   // long receiver hold-off requested by the sender

    bankers_safety_check_unit #(.PROCESSES(NPROC)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .process(process),
        .amount_a(amount_a), .amount_b(amount_b), .amount_c(amount_c),
        .need_a(need_a), .need_b(need_b), .need_c(need_c),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .order_process(order_process), .last(last)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Time limit
    initial
    begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

    // Note accepted items and check results at each edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_item(kind, process, '{amount_a, amount_b, amount_c},
                            '{need_a, need_b, need_c});
        if (rst_n && out_valid && out_ready)
            board.check_result(status, order_process, last);
    end

    // Receiver: random stall bursts and the long hold-off
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_ready <= 1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic [1:0] k, logic [2:0] p, logic [7:0] a0,
                             logic [7:0] a1, logic [7:0] a2, logic [7:0] n0,
                             logic [7:0] n1, logic [7:0] n2);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k; process <= p;
        amount_a <= a0; amount_b <= a1; amount_c <= a2;
        need_a <= n0; need_b <= n1; need_c <= n2;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_load(int p, int a0, int a1, int a2, int n0, int n1, int n2);
        send_item(KIND_LOAD, 3'(p), 8'(a0), 8'(a1), 8'(a2), 8'(n0), 8'(n1), 8'(n2));
    endtask

    task automatic send_avail(int a0, int a1, int a2);
        send_item(KIND_AVAIL, 3'($urandom_range(0, 7)), 8'(a0), 8'(a1), 8'(a2),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_request(int p, int a0, int a1, int a2);
        send_item(KIND_REQUEST, 3'(p), 8'(a0), 8'(a1), 8'(a2),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Small random scenario: rows sized so requests often pass both checks
    task automatic send_scenario(int scale);
        for (int p = 0; p < NPROC; p++)
            send_load(p, $urandom_range(0, scale), $urandom_range(0, scale),
                      $urandom_range(0, scale), $urandom_range(0, scale),
                      $urandom_range(0, scale), $urandom_range(0, scale));
        send_avail($urandom_range(0, 2 * scale), $urandom_range(0, 2 * scale),
                   $urandom_range(0, 2 * scale));
        repeat ($urandom_range(2, 6))
            send_request($urandom_range(0, 7), $urandom_range(0, scale / 2),
                         $urandom_range(0, scale / 2), $urandom_range(0, scale / 2));
    endtask

    // Stimulus
    initial
    begin
        int sent;
        int pick;
        board = new();
        calm = 0;
        hold_cycles = 0;
        rst_n = 0;
        in_valid = 0;
        kind = 0; process = 0;
        amount_a = 0; amount_b = 0; amount_c = 0;
        need_a = 0; need_b = 0; need_c = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: all-zero state is safe
        send_request(0, 0, 0, 0);
        // Extremes of loads and availability
        send_load(7, 255, 255, 255, 0, 0, 0);
        send_load(0, 0, 0, 0, 255, 255, 255);
        send_avail(255, 255, 255);
        // Overflow of allocation
        send_request(7, 0, 0, 0);
        send_load(1, 250, 0, 0, 10, 0, 0);
        send_request(1, 10, 0, 0);
        // Over need, blocked, safe grant
        send_request(2, 1, 0, 0);
        send_avail(1, 0, 0);
        send_request(0, 2, 0, 0);
        send_request(0, 1, 0, 0);
        // Unsafe: process 0 needs more than anyone can return
        send_load(7, 0, 0, 0, 0, 0, 0);
        send_load(1, 0, 0, 0, 0, 0, 0);
        send_avail(5, 5, 5);
        send_request(0, 1, 1, 1);
        // Unused kind is ignored
        send_item(2'd3, 3'd5, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF, 8'h55);
        send_load(0, 0, 0, 0, 0, 0, 0);
        send_request(0, 0, 0, 0);

        // Long receiver hold-off while the sender keeps offering
        hold_cycles = 400;
        sent = 18;
        send_scenario(20);

        // Random part
        while (sent < 250)
        begin
            if (sent > 210) calm = 1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                send_scenario(pick < 4 ? 16 : 255);
                sent += 12;
            end
            else if (pick < 9)
            begin
                send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                send_request($urandom_range(0, 7), $urandom_range(0, 3),
                             $urandom_range(0, 3), $urandom_range(0, 3));
                sent++;
            end
        end
        in_valid <= 0;

        // Drain
        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
